// ===== sv/iucc_pkg.sv =====
// ----------------------------------------------------------------------------
// iucc_pkg
// Shared types and constants for the interval union coverage counter.
// ----------------------------------------------------------------------------
`default_nettype none

package iucc_pkg;

  localparam int VAL_W = 30;          // interval bound and result count width
  localparam int CNT_W = VAL_W + 1;   // running total, holds 2^30 exactly

  typedef enum logic [1:0] {
    ADD_OK   = 2'd0,
    ADD_FULL = 2'd1,
    ADD_BAD  = 2'd2
  } add_status_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FINISH,
    ST_DONE
  } state_t;

  // controller -> datapath
  typedef struct packed {
    logic        start;     // item accepted: load bounds, clear scan state
    logic        scan;      // table pass in progress
    logic        commit;    // write last entry, update totals
    logic        out_load;  // load the result register
    add_status_t code;      // status for the result
  } ctrl_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic bad;        // start after end on the input ports
    logic empty;      // table holds no entries
    logic scan_last;  // last stored entry is being evaluated
    logic reject;     // insertion needed but table full (during pass)
    logic fin_full;   // insertion needed but table full (end of pass)
    logic out_free;   // result register can take a new item
  } dp_stat_t;

endpackage

`default_nettype wire

// ===== sv/iucc_ctrl.sv =====
// ----------------------------------------------------------------------------
// iucc_ctrl
// Sequencer: accept, table pass, commit, result hand-off.
// ----------------------------------------------------------------------------
`default_nettype none

module iucc_ctrl (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire iucc_pkg::dp_stat_t stat,
  output iucc_pkg::ctrl_cmd_t     cmd
);

  iucc_pkg::state_t      state_r, state_nxt;
  iucc_pkg::add_status_t code_r, code_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= iucc_pkg::ST_IDLE;
      code_r  <= iucc_pkg::ADD_OK;
    end else begin
      state_r <= state_nxt;
      code_r  <= code_nxt;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    code_nxt  = code_r;
    unique case (state_r)
      iucc_pkg::ST_IDLE: begin
        if (in_valid) begin
          if (stat.bad) begin
            state_nxt = iucc_pkg::ST_DONE;
            code_nxt  = iucc_pkg::ADD_BAD;
          end else if (stat.empty) begin
            state_nxt = iucc_pkg::ST_FINISH;
          end else begin
            state_nxt = iucc_pkg::ST_SCAN;
          end
        end
      end
      iucc_pkg::ST_SCAN: begin
        if (stat.reject) begin
          state_nxt = iucc_pkg::ST_DONE;
          code_nxt  = iucc_pkg::ADD_FULL;
        end else if (stat.scan_last) begin
          state_nxt = iucc_pkg::ST_FINISH;
        end
      end
      iucc_pkg::ST_FINISH: begin
        state_nxt = iucc_pkg::ST_DONE;
        code_nxt  = stat.fin_full ? iucc_pkg::ADD_FULL : iucc_pkg::ADD_OK;
      end
      iucc_pkg::ST_DONE: begin
        if (stat.out_free) begin
          state_nxt = iucc_pkg::ST_IDLE;
        end
      end
      default: state_nxt = iucc_pkg::ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    in_stall     = 1'b1;
    cmd.start    = 1'b0;
    cmd.scan     = 1'b0;
    cmd.commit   = 1'b0;
    cmd.out_load = 1'b0;
    cmd.code     = code_r;
    unique case (state_r)
      iucc_pkg::ST_IDLE: begin
        in_stall  = 1'b0;
        cmd.start = in_valid;
      end
      iucc_pkg::ST_SCAN:   cmd.scan     = 1'b1;
      iucc_pkg::ST_FINISH: cmd.commit   = !stat.fin_full;
      iucc_pkg::ST_DONE:   cmd.out_load = stat.out_free;
      default: ;
    endcase
  end

endmodule

`default_nettype wire

// ===== sv/iucc_dpath.sv =====
// ----------------------------------------------------------------------------
// iucc_dpath
// Interval table memories, streaming merge/compaction pass, totals and the
// result register.
// ----------------------------------------------------------------------------
`default_nettype none

module iucc_dpath #(
  parameter int MAX_INTERVALS = 256,
  parameter int AW            = $clog2(MAX_INTERVALS),
  parameter int CW            = $clog2(MAX_INTERVALS + 1)
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire iucc_pkg::ctrl_cmd_t           cmd,
  output iucc_pkg::dp_stat_t                 stat,
  input  wire logic [iucc_pkg::VAL_W-1:0]    in_range_start,
  input  wire logic [iucc_pkg::VAL_W-1:0]    in_range_end,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic [iucc_pkg::VAL_W-1:0]         out_covered_count,
  output logic [1:0]                         out_add_status,
  output logic [CW-1:0]                      out_entries_in_use
);

  localparam int VW = iucc_pkg::VAL_W;
  localparam int NW = iucc_pkg::CNT_W;

  // interval table, sorted by start
  logic [VW-1:0] mem_s [MAX_INTERVALS];
  logic [VW-1:0] mem_e [MAX_INTERVALS];

  logic [VW-1:0] rd_s_r, rd_e_r;
  logic          re, we;
  logic [VW-1:0] wd_s, wd_e;

  // control state
  logic          rd_vld_r, rd_vld_nxt;
  logic          skip_done_r, skip_done_nxt;
  logic          tail_on_r, tail_on_nxt;
  logic          merged_r, merged_nxt;
  logic [CW-1:0] n_r, n_nxt;
  logic [NW-1:0] covered_r, covered_nxt;
  logic          out_valid_r, out_valid_nxt;

  // payload
  logic [CW-1:0] rp_r, rp_nxt;
  logic [CW-1:0] wp_r, wp_nxt;
  logic [AW-1:0] q_r, q_nxt;
  logic [VW-1:0] s_r, s_nxt, e_r, e_nxt;
  logic [VW-1:0] ns_r, ns_nxt, ne_r, ne_nxt;
  logic [VW-1:0] hold_s_r, hold_s_nxt, hold_e_r, hold_e_nxt;
  logic [NW-1:0] removed_r, removed_nxt;
  logic [VW-1:0] oc_r, oc_nxt;
  logic [1:0]    os_r, os_nxt;
  logic [CW-1:0] on_r, on_nxt;

  logic          proc, ent_skip, ent_merge, tail_start, full_now;
  logic [NW-1:0] ent_len, new_len;
  logic [CW-1:0] q_cw;

  assign q_cw      = CW'(q_r);
  assign proc      = cmd.scan && rd_vld_r;
  // entry lies wholly left of the new interval and does not touch it
  assign ent_skip  = ({1'b0, rd_e_r} + NW'(1)) < {1'b0, s_r};
  assign ent_merge = rd_s_r <= e_r;
  assign ent_len   = {1'b0, rd_e_r - rd_s_r} + NW'(1);
  assign new_len   = {1'b0, ne_r - ns_r} + NW'(1);
  assign full_now  = n_r == CW'(MAX_INTERVALS);
  assign tail_start = proc && !tail_on_r && !(!skip_done_r && ent_skip) && !ent_merge;

  assign stat.bad       = in_range_start > in_range_end;
  assign stat.empty     = n_r == '0;
  assign stat.scan_last = rd_vld_r && ((q_cw + CW'(1)) == n_r);
  assign stat.reject    = tail_start && !merged_r && full_now;
  assign stat.fin_full  = !tail_on_r && !merged_r && full_now;
  assign stat.out_free  = !out_valid_r || !out_stall;

  assign re = cmd.scan && (rp_r < n_r);

  // write port: writes always land at or behind the read pointer
  always_comb begin
    we   = 1'b0;
    wd_s = hold_s_r;
    wd_e = hold_e_r;
    if (cmd.commit) begin
      we = 1'b1;
      if (!tail_on_r) begin
        wd_s = ns_r;
        wd_e = ne_r;
      end
    end else if (proc && tail_on_r) begin
      we = 1'b1;
    end else if (tail_start && !stat.reject) begin
      we   = 1'b1;
      wd_s = ns_r;
      wd_e = ne_r;
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem_s[wp_r[AW-1:0]] <= wd_s;
      mem_e[wp_r[AW-1:0]] <= wd_e;
    end
    if (re) begin
      rd_s_r <= mem_s[rp_r[AW-1:0]];
      rd_e_r <= mem_e[rp_r[AW-1:0]];
    end
  end

  always_comb begin
    rd_vld_nxt    = rd_vld_r;
    skip_done_nxt = skip_done_r;
    tail_on_nxt   = tail_on_r;
    merged_nxt    = merged_r;
    n_nxt         = n_r;
    covered_nxt   = covered_r;
    out_valid_nxt = out_valid_r;
    rp_nxt        = rp_r;
    wp_nxt        = wp_r;
    q_nxt         = q_r;
    s_nxt         = s_r;
    e_nxt         = e_r;
    ns_nxt        = ns_r;
    ne_nxt        = ne_r;
    hold_s_nxt    = hold_s_r;
    hold_e_nxt    = hold_e_r;
    removed_nxt   = removed_r;
    oc_nxt        = oc_r;
    os_nxt        = os_r;
    on_nxt        = on_r;

    if (cmd.start) begin
      rd_vld_nxt    = 1'b0;
      skip_done_nxt = 1'b0;
      tail_on_nxt   = 1'b0;
      merged_nxt    = 1'b0;
      rp_nxt        = '0;
      wp_nxt        = '0;
      s_nxt         = in_range_start;
      e_nxt         = in_range_end;
      ns_nxt        = in_range_start;
      ne_nxt        = in_range_end;
      removed_nxt   = '0;
    end

    if (cmd.scan) begin
      rd_vld_nxt = re;
      if (re) begin
        q_nxt  = rp_r[AW-1:0];
        rp_nxt = rp_r + CW'(1);
      end
    end

    if (proc) begin
      if (tail_on_r) begin
        wp_nxt     = wp_r + CW'(1);
        hold_s_nxt = rd_s_r;
        hold_e_nxt = rd_e_r;
      end else if (!skip_done_r && ent_skip) begin
        wp_nxt = q_cw + CW'(1);
      end else begin
        skip_done_nxt = 1'b1;
        if (ent_merge) begin
          merged_nxt  = 1'b1;
          removed_nxt = removed_r + ent_len;
          if (rd_s_r < ns_r) ns_nxt = rd_s_r;
          if (rd_e_r > ne_r) ne_nxt = rd_e_r;
        end else if (!stat.reject) begin
          tail_on_nxt = 1'b1;
          wp_nxt      = wp_r + CW'(1);
          hold_s_nxt  = rd_s_r;
          hold_e_nxt  = rd_e_r;
        end
      end
    end

    if (cmd.commit) begin
      n_nxt       = wp_r + CW'(1);
      covered_nxt = covered_r - removed_r + new_len;
    end

    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
      oc_nxt = covered_r[NW-1] ? '1 : covered_r[VW-1:0];
      os_nxt = cmd.code;
      on_nxt = n_r;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_vld_r    <= 1'b0;
      skip_done_r <= 1'b0;
      tail_on_r   <= 1'b0;
      merged_r    <= 1'b0;
      n_r         <= '0;
      covered_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      rd_vld_r    <= rd_vld_nxt;
      skip_done_r <= skip_done_nxt;
      tail_on_r   <= tail_on_nxt;
      merged_r    <= merged_nxt;
      n_r         <= n_nxt;
      covered_r   <= covered_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rp_r      <= rp_nxt;
    wp_r      <= wp_nxt;
    q_r       <= q_nxt;
    s_r       <= s_nxt;
    e_r       <= e_nxt;
    ns_r      <= ns_nxt;
    ne_r      <= ne_nxt;
    hold_s_r  <= hold_s_nxt;
    hold_e_r  <= hold_e_nxt;
    removed_r <= removed_nxt;
    oc_r      <= oc_nxt;
    os_r      <= os_nxt;
    on_r      <= on_nxt;
  end

  assign out_valid          = out_valid_r;
  assign out_covered_count  = oc_r;
  assign out_add_status     = os_r;
  assign out_entries_in_use = on_r;

endmodule

`default_nettype wire

// ===== sv/interval_union_coverage_counter.sv =====
// ----------------------------------------------------------------------------
// interval_union_coverage_counter
// Keeps a sorted table of disjoint closed intervals and the number of
// integers they cover; each item adds one interval and returns the total.
// ----------------------------------------------------------------------------
// Each accepted item makes one pass over the stored table, one entry per
// cycle through the table memory's single read port, merging overlapping or
// left-adjacent entries and compacting or opening a slot as it goes. An item's
// pass covers the n entries stored when it arrives (at most MAX_INTERVALS);
// an interval with start after end skips the pass and goes straight to its
// result, and a full-table rejection may end the pass early.
// The next item is taken once the result sits in the output register.
// No clearing pass is needed after reset.
`default_nettype none

module interval_union_coverage_counter #(
  parameter int MAX_INTERVALS = 256
) (
  input  wire logic                                    clk,
  input  wire logic                                    rst_n,
  input  wire logic                                    in_valid,
  output logic                                         in_stall,
  input  wire logic [iucc_pkg::VAL_W-1:0]              in_range_start,
  input  wire logic [iucc_pkg::VAL_W-1:0]              in_range_end,
  output logic                                         out_valid,
  input  wire logic                                    out_stall,
  output logic [iucc_pkg::VAL_W-1:0]                   out_covered_count,
  output logic [1:0]                                   out_add_status,
  output logic [$clog2(MAX_INTERVALS + 1)-1:0]         out_entries_in_use
);

  localparam int AW = $clog2(MAX_INTERVALS);
  localparam int CW = $clog2(MAX_INTERVALS + 1);

  iucc_pkg::ctrl_cmd_t cmd;
  iucc_pkg::dp_stat_t  stat;

  iucc_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  iucc_dpath #(
    .MAX_INTERVALS (MAX_INTERVALS),
    .AW            (AW),
    .CW            (CW)
  ) u_dpath (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .stat               (stat),
    .in_range_start     (in_range_start),
    .in_range_end       (in_range_end),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_covered_count  (out_covered_count),
    .out_add_status     (out_add_status),
    .out_entries_in_use (out_entries_in_use)
  );

endmodule

`default_nettype wire

// ===== sv/iucc_checker.sv =====
// ----------------------------------------------------------------------------
// iucc_checker
// Port-level checks on the result channel, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module iucc_checker #(
  parameter int MAX_INTERVALS = 256
) (
  input wire logic                                clk,
  input wire logic                                rst_n,
  input wire logic                                out_valid,
  input wire logic                                out_stall,
  input wire logic [iucc_pkg::VAL_W-1:0]          out_covered_count,
  input wire logic [1:0]                          out_add_status,
  input wire logic [$clog2(MAX_INTERVALS + 1)-1:0] out_entries_in_use
);

  // a stalled item holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_covered_count)
      && $stable(out_add_status) && $stable(out_entries_in_use))
    else $error("result changed while stalled");

  a_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_add_status == iucc_pkg::ADD_OK
      || out_add_status == iucc_pkg::ADD_FULL
      || out_add_status == iucc_pkg::ADD_BAD))
    else $error("undefined status code");

  // a full rejection only happens with every slot in use
  a_full: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_add_status == iucc_pkg::ADD_FULL
      |-> out_entries_in_use == ($clog2(MAX_INTERVALS + 1))'(MAX_INTERVALS))
    else $error("full status with free slots");

  // an accepted add leaves at least one interval and a nonzero count
  a_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_add_status == iucc_pkg::ADD_OK
      |-> out_entries_in_use != '0 && out_covered_count != '0)
    else $error("accepted add left table empty");

endmodule

bind interval_union_coverage_counter iucc_checker #(
  .MAX_INTERVALS (MAX_INTERVALS)
) u_iucc_checker (
  .clk                (clk),
  .rst_n              (rst_n),
  .out_valid          (out_valid),
  .out_stall          (out_stall),
  .out_covered_count  (out_covered_count),
  .out_add_status     (out_add_status),
  .out_entries_in_use (out_entries_in_use)
);

`default_nettype wire

// ===== bench/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the interval union coverage counter.
// A scoreboard class keeps its own sorted interval table and count, works
// out the result of every accepted add and compares it field by field with
// what the block returns. Directed adds cover merges, adjacency on either
// side, bad intervals and the range extremes; random phases then alternate
// between filling the table up to its capacity and collapsing it with wide
// merges, under random sender bursts and receiver stalls.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int VAL_W       = iucc_pkg::VAL_W;
  localparam int CNT_W       = iucc_pkg::CNT_W;
  localparam int TABLE_DEPTH = 256;
  localparam int ENT_W       = $clog2(TABLE_DEPTH + 1);
  localparam int VAL_MAX     = (1 << VAL_W) - 1;
  // ~1250 items, each with a pass over up to TABLE_DEPTH entries, plus stalls and gaps
  localparam int unsigned CYCLE_LIMIT  = 2_000_000;
  localparam int          DRAIN_CYCLES = TABLE_DEPTH + 40;

  typedef struct {
    bit [VAL_W-1:0]        count;
    iucc_pkg::add_status_t status;
    bit [ENT_W-1:0]        entries;
  } add_result_t;

  typedef enum {RX_FREE, RX_LIGHT, RX_HEAVY, RX_PULSE} rx_mode_t;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_valid = 1'b0;
  logic                   in_stall;
  logic [VAL_W-1:0]       in_range_start = '0;
  logic [VAL_W-1:0]       in_range_end = '0;
  logic                   out_valid;
  logic                   out_stall = 1'b0;
  logic [VAL_W-1:0]       out_covered_count;
  logic [1:0]             out_add_status;
  logic [ENT_W-1:0]       out_entries_in_use;

  class union_scoreboard;
    bit [VAL_W-1:0] lo_tab [TABLE_DEPTH];
    bit [VAL_W-1:0] hi_tab [TABLE_DEPTH];
    int unsigned    n_entries;
    bit [CNT_W-1:0] covered;
    add_result_t    expected_results[$];
    int unsigned    mismatches, n_ok, n_full, n_bad, n_sat, peak_entries;

    // Apply one add to the shadow table and queue the result it must give.
    function void note_add(bit [VAL_W-1:0] s, bit [VAL_W-1:0] e);
      add_result_t    r;
      int unsigned    i, j, k, m;
      bit [CNT_W-1:0] removed;
      bit [VAL_W-1:0] ns, ne;
      removed = '0;
      if (s > e) begin
        r.status = iucc_pkg::ADD_BAD;
        n_bad++;
      end else begin
        // first entry whose end reaches s-1 (touching on the left merges)
        i = 0;
        while (i < n_entries && longint'(hi_tab[i]) + 1 < longint'(s))
          i++;
        j = i;
        while (j < n_entries && lo_tab[j] <= e) begin
          removed += CNT_W'(hi_tab[j]) - CNT_W'(lo_tab[j]) + 1'b1;
          j++;
        end
        k = j - i;
        if (k == 0 && n_entries >= TABLE_DEPTH) begin
          r.status = iucc_pkg::ADD_FULL;
          n_full++;
        end else begin
          ns = s;
          ne = e;
          if (k > 0) begin
            if (lo_tab[i] < ns) ns = lo_tab[i];
            if (hi_tab[j-1] > ne) ne = hi_tab[j-1];
          end
          if (k == 0) begin
            for (m = n_entries; m > i; m--) begin
              lo_tab[m] = lo_tab[m-1];
              hi_tab[m] = hi_tab[m-1];
            end
            n_entries++;
          end else if (k > 1) begin
            for (m = i + 1; m + k - 1 < n_entries; m++) begin
              lo_tab[m] = lo_tab[m+k-1];
              hi_tab[m] = hi_tab[m+k-1];
            end
            n_entries -= k - 1;
          end
          lo_tab[i] = ns;
          hi_tab[i] = ne;
          covered = covered - removed + (CNT_W'(ne) - CNT_W'(ns) + 1'b1);
          r.status = iucc_pkg::ADD_OK;
          n_ok++;
          if (n_entries > peak_entries) peak_entries = n_entries;
        end
      end
      if (covered > CNT_W'(VAL_MAX)) begin
        r.count = VAL_W'(VAL_MAX);
        n_sat++;
      end else begin
        r.count = covered[VAL_W-1:0];
      end
      r.entries = ENT_W'(n_entries);
      expected_results = {expected_results, r};
    endfunction

    function void check_result(logic [VAL_W-1:0] count, logic [1:0] status,
                               logic [ENT_W-1:0] entries);
      add_result_t want;
      if (expected_results.size() == 0) begin
        $display("%0t: result with nothing outstanding: count %0d status %0d entries %0d",
                 $time, count, status, entries);
        mismatches++;
        return;
      end
      want = expected_results.pop_front();
      if (count !== want.count) begin
        $display("%0t: covered_count expected %0d, got %0d", $time, want.count, count);
        mismatches++;
      end
      if (status !== want.status) begin
        $display("%0t: add_status expected %0d, got %0d", $time, want.status, status);
        mismatches++;
      end
      if (entries !== want.entries) begin
        $display("%0t: entries_in_use expected %0d, got %0d", $time, want.entries, entries);
        mismatches++;
      end
    endfunction
  endclass

  union_scoreboard tracker;
  int unsigned     burst_left = 0;
  int unsigned     cycle_count = 0;
  int unsigned     rx_tick = 0;
  rx_mode_t        rx_mode = RX_FREE;

  interval_union_coverage_counter #(.MAX_INTERVALS(TABLE_DEPTH)) DUT (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_range_start    (in_range_start),
    .in_range_end      (in_range_end),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_covered_count (out_covered_count),
    .out_add_status    (out_add_status),
    .out_entries_in_use(out_entries_in_use)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("%0t: timed out after %0d cycles", $time, cycle_count);
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // receiver: stall behaviour is re-picked at random among free, light, heavy and pulsed
  always @(negedge clk) begin
    if (rx_tick % 700 == 0) rx_mode = rx_mode_t'($urandom_range(0, 3));
    rx_tick++;
    case (rx_mode)
      RX_FREE:  out_stall <= 1'b0;
      RX_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
      RX_HEAVY: out_stall <= ($urandom_range(0, 3) != 0);
      default:  out_stall <= (rx_tick[4:2] == 3'b111);
    endcase
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall)
      tracker.check_result(out_covered_count, out_add_status, out_entries_in_use);
  end

  function automatic longint rnd(longint lo_v, longint hi_v);
    return lo_v + longint'($urandom_range(0, hi_v - lo_v));
  endfunction

  function automatic bit [VAL_W-1:0] clamp_val(longint v);
    if (v < 0) return '0;
    if (v > VAL_MAX) return VAL_W'(VAL_MAX);
    return v[VAL_W-1:0];
  endfunction

  // Called at a falling edge; returns at the falling edge after acceptance.
  task automatic send_paced(input bit [VAL_W-1:0] s, input bit [VAL_W-1:0] e);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      burst_left = $urandom_range(1, 16);
    end
    burst_left--;
    in_range_start <= s;
    in_range_end   <= e;
    in_valid       <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    tracker.note_add(s, e);
    @(negedge clk);
  endtask

  // grow: mostly fresh disjoint intervals, so the table fills and refuses adds;
  // otherwise mostly merges against stored entries, which collapse the table.
  task automatic run_random_phase(input int unsigned count, input bit grow);
    int unsigned pick, idx, idx2, n, t_new, t_near, t_bad;
    longint      lo, hi, a, b;
    t_new  = grow ? 80 : 15;
    t_near = t_new + (grow ? 10 : 30);
    t_bad  = t_near + 5;
    repeat (count) begin
      n    = tracker.n_entries;
      pick = (n == 0) ? 0 : $urandom_range(0, 99);
      if (pick < t_new) begin
        a = ($urandom_range(0, 19) == 0) ? rnd(0, 31) : rnd(0, VAL_MAX);
        b = a + (($urandom_range(0, 9) == 0) ? rnd(0, 1 << 20) : rnd(0, 15));
      end else if (pick < t_near) begin
        idx = $urandom_range(0, n - 1);
        lo  = tracker.lo_tab[idx];
        hi  = tracker.hi_tab[idx];
        case ($urandom_range(0, 3))
          0: begin
            a = hi + 1;              // touches on the left: merged
            b = a + rnd(0, 7);
          end
          1: begin
            b = lo - 1;              // touches on the right: kept apart
            a = b - rnd(0, 7);
          end
          2: begin
            a = rnd(lo - 3, hi);
            b = a + rnd(0, 7);
          end
          default: begin
            a = lo - rnd(0, 2);
            b = hi + rnd(0, 2);
          end
        endcase
      end else if (pick < t_bad) begin
        a = rnd(1, VAL_MAX);
        b = rnd(0, a - 1);
      end else begin
        idx  = $urandom_range(0, n - 1);
        idx2 = idx + $urandom_range(1, grow ? 3 : 8);
        if (idx2 >= n) idx2 = n - 1;
        a = longint'(tracker.lo_tab[idx]) - rnd(0, 2);
        b = longint'(tracker.hi_tab[idx2]) + rnd(0, 2);
      end
      send_paced(clamp_val(a), clamp_val(b));
    end
  endtask

  initial begin
    tracker = new;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed: merges, adjacency both sides, bad intervals, bit patterns
    send_paced(10, 20);
    send_paced(30, 40);
    send_paced(21, 25);               // starts right after a stored end
    send_paced(5, 9);                 // ends right before a stored start
    send_paced(50, 45);
    send_paced(1, 1);
    send_paced(2, 3);
    send_paced(4, 4);
    send_paced(7, 35);                // swallows several entries
    send_paced(VAL_MAX, VAL_MAX);
    send_paced(VAL_MAX - 1, VAL_MAX);
    send_paced(200, 199);
    send_paced(30'h2AAA_AAAA, 30'h2AAA_AAAF);
    send_paced(30'h1555_5555, 30'h1555_5555);
    send_paced(100, 100);
    send_paced(99, 101);
    send_paced(102, 110);
    send_paced(50, 98);
    send_paced(VAL_MAX, 1);

    // full-table refusals come from the fill phases
    run_random_phase(350, 1'b1);
    run_random_phase(250, 1'b0);
    run_random_phase(350, 1'b1);
    run_random_phase(300, 1'b0);

    // whole range, then zero on top of it: the count saturates
    send_paced(1, VAL_MAX);
    send_paced(0, 0);
    send_paced(0, VAL_MAX);
    send_paced(VAL_MAX, 0);
    in_valid <= 1'b0;

    while (tracker.expected_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Adds checked: %0d stored, %0d refused on a full table, %0d with start after end.",
             tracker.n_ok, tracker.n_full, tracker.n_bad);
    $display("Table peaked at %0d entries; %0d results with a saturated count.",
             tracker.peak_entries, tracker.n_sat);
    if (tracker.mismatches == 0 && tracker.expected_results.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
